[rtl/core/pqe_pkg.sv]
// ----------------------------------------------------------------------------
// pqe_pkg
// Types and constants shared by the piecewise quadratic core and its units.
// ----------------------------------------------------------------------------
package pqe_pkg;

  localparam logic [1:0] KIND_LOAD      = 2'd0;
  localparam logic [1:0] KIND_EVALUATE  = 2'd1;
  localparam logic [1:0] KIND_INTEGRATE = 2'd2;

  localparam logic [1:0] STATUS_OK      = 2'd0;
  localparam logic [1:0] STATUS_MISS    = 2'd1;
  localparam logic [1:0] STATUS_SAT     = 2'd2;

  // Arithmetic word of the shared unit and the accumulators.
  localparam int unsigned AccW = 64;
  localparam int unsigned OpAW = 42;
  localparam int unsigned OpBW = 27;

  typedef enum logic [1:0] {
    SH_NONE = 2'd0,
    SH_24   = 2'd1,
    SH_25   = 2'd2
  } shift_t;

  typedef struct packed {
    logic [1:0]         kind;
    logic [9:0]         entry_index;
    logic [24:0]        seg_start;
    logic [24:0]        seg_end;
    logic signed [39:0] coef_quad;
    logic signed [39:0] coef_lin;
    logic signed [39:0] coef_const;
    logic [24:0]        sample_x;
  } item_t;

  typedef struct packed {
    logic signed [47:0] value;
    logic [1:0]         status;
  } result_t;

  typedef struct packed {
    logic [24:0]        seg_start;
    logic [24:0]        seg_end;
    logic signed [39:0] coef_quad;
    logic signed [39:0] coef_lin;
    logic signed [39:0] coef_const;
  } entry_t;

endpackage

[rtl/core/pqe_table.sv]
// ----------------------------------------------------------------------------
// pqe_table
// Segment table: one write port and one registered read port.
// ----------------------------------------------------------------------------
module pqe_table import pqe_pkg::*; #(
  parameter int unsigned DEPTH = 1024,
  parameter int unsigned IW    = 10
) (
  input  logic          clk,
  input  logic          we,
  input  logic [IW-1:0] waddr,
  input  entry_t        wdata,
  input  logic [IW-1:0] raddr,
  output entry_t        rdata
);

  entry_t mem [DEPTH];

  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
    rdata <= mem[raddr];
  end

endmodule

[rtl/core/pqe_mul.sv]
// ----------------------------------------------------------------------------
// pqe_mul
// Shared signed multiplier with rounding shift, two partial products.
// ----------------------------------------------------------------------------
module pqe_mul import pqe_pkg::*; (
  input  logic                   clk,
  input  logic                   rst,
  input  logic                   start,
  input  logic signed [OpAW-1:0] op_a,
  input  logic signed [OpBW-1:0] op_b,
  input  shift_t                 sh,
  output logic                   done,
  output logic signed [AccW-1:0] res
);

  localparam int unsigned HW = OpAW / 2;
  localparam int unsigned PW = HW + OpBW;
  localparam int unsigned FW = OpAW + OpBW;

  logic [OpAW-1:0] ma;
  logic [OpBW-1:0] mb;
  logic            neg;
  shift_t          sh_q;
  logic [2:0]      phase;
  logic [PW-1:0]   p_lo;
  logic [PW-1:0]   p_hi;
  logic [PW-1:0]   pp;
  logic [FW-1:0]   prod;
  logic [FW-1:0]   rnd;
  logic [AccW-1:0] mag;

  // One multiplier serves both halves of the wide operand.
  assign pp = (phase[1] ? ma[OpAW-1:HW] : ma[HW-1:0]) * mb;

  always_comb begin
    prod = FW'(p_lo) + (FW'(p_hi) << HW);
    unique case (sh_q)
      SH_24:   rnd = (prod + (FW'(1) << 23)) >> 24;
      SH_25:   rnd = (prod + (FW'(1) << 24)) >> 25;
      default: rnd = prod;
    endcase
    mag = AccW'(rnd);
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      phase <= '0;
      done  <= 1'b0;
    end else begin
      phase <= start ? 3'b001 : {phase[1:0], 1'b0};
      done  <= phase[2];
    end
    if (start) begin
      ma   <= op_a[OpAW-1] ? OpAW'(-op_a) : OpAW'(op_a);
      mb   <= op_b[OpBW-1] ? OpBW'(-op_b) : OpBW'(op_b);
      neg  <= op_a[OpAW-1] ^ op_b[OpBW-1];
      sh_q <= sh;
    end
    if (phase[0]) begin
      p_lo <= pp;
    end
    if (phase[1]) begin
      p_hi <= pp;
    end
    if (phase[2]) begin
      res <= neg ? -$signed(mag) : $signed(mag);
    end
  end

endmodule

[rtl/core/pqe_div3.sv]
// ----------------------------------------------------------------------------
// pqe_div3
// Signed divide by three, rounding half away from zero, four bits a cycle.
// ----------------------------------------------------------------------------
module pqe_div3 import pqe_pkg::*; (
  input  logic                   clk,
  input  logic                   rst,
  input  logic                   start,
  input  logic signed [AccW-1:0] v,
  output logic                   done,
  output logic signed [AccW-1:0] q
);

  localparam int unsigned DW    = 44;
  localparam int unsigned Digit = 4;
  localparam int unsigned Steps = DW / Digit;
  localparam int unsigned SW    = $clog2(Steps + 1);

  logic [DW-1:0]  num;
  logic [DW-1:0]  quo;
  logic [1:0]     rem;
  logic           neg;
  logic [SW-1:0]  left;
  logic [2:0]     r;
  logic [1:0]     rem_next;
  logic [Digit-1:0] qd;
  logic [DW-1:0]  absv;

  assign absv = v[AccW-1] ? DW'(-v) : DW'(v);

  always_comb begin
    rem_next = rem;
    qd       = '0;
    for (int k = 0; k < Digit; k++) begin
      r = {rem_next, num[DW-1-k]};
      if (r >= 3'd3) begin
        r = r - 3'd3;
        qd[Digit-1-k] = 1'b1;
      end
      rem_next = r[1:0];
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      left <= '0;
      done <= 1'b0;
    end else begin
      done <= !start && (left == SW'(1));
      if (start) begin
        left <= SW'(Steps);
      end else if (left != '0) begin
        left <= left - SW'(1);
      end
    end
    if (start) begin
      num <= absv + DW'(1);
      rem <= '0;
      neg <= v[AccW-1];
    end else if (left != '0) begin
      num <= num << Digit;
      rem <= rem_next;
      quo <= {quo[DW-Digit-1:0], qd};
    end
  end

  assign q = neg ? -$signed(AccW'(quo)) : $signed(AccW'(quo));

endmodule

[rtl/core/piecewise_quadratic_eval_integrate_core.sv]
// ----------------------------------------------------------------------------
// piecewise_quadratic_eval_integrate_core
// Piecewise quadratic table with evaluate and integrate under one sequencer.
// ----------------------------------------------------------------------------
// A load item writes one table slot and returns a zero result. An evaluate
// item bisects the active slots, reading in S_SRCH and comparing in S_SCMP
// at each step, and then runs two passes of the shared multiplier. An
// integrate item walks every active slot: eight passes through the shared
// multiplier and one divide by three for each slot. The block takes a new
// item only when the previous one is done; the result register lets the next
// item start while a result waits.
module piecewise_quadratic_eval_integrate_core import pqe_pkg::*; #(
  parameter int unsigned MAX_SEGMENTS = 1024
) (
  input  logic        clk,
  input  logic        rst,
  input  logic        item_valid,
  output logic        item_stall,
  input  item_t       item,
  output logic        result_valid,
  input  logic        result_stall,
  output result_t     result,
  input  logic        cfg_valid,
  output logic        cfg_ready,
  input  logic [10:0] cfg_data
);

  localparam int unsigned IW = $clog2(MAX_SEGMENTS);
  localparam int unsigned CW = $clog2(MAX_SEGMENTS + 1);
  localparam int unsigned NW = (CW > 11) ? CW : 11;

  localparam logic signed [AccW-1:0] ValMax = AccW'(64'sh7FFF_FFFF_FFFF);
  localparam logic signed [AccW-1:0] ValMin = -AccW'(64'sh8000_0000_0000);

  typedef enum logic [17:0] {
    S_IDLE = 18'h00001,
    S_SRCH = 18'h00002,
    S_SCMP = 18'h00004,
    S_SEL  = 18'h00008,
    S_EM1  = 18'h00010,
    S_EM2  = 18'h00020,
    S_IRD  = 18'h00040,
    S_ILAT = 18'h00080,
    S_ITC  = 18'h00100,
    S_IDE  = 18'h00200,
    S_ITB  = 18'h00400,
    S_IQ1  = 18'h00800,
    S_IQ2  = 18'h01000,
    S_IQ3  = 18'h02000,
    S_IQ4  = 18'h04000,
    S_ITA  = 18'h08000,
    S_IDIV = 18'h10000,
    S_EMIT = 18'h20000
  } state_t;

  state_t                 state;
  logic [10:0]            segment_count;
  logic [CW-1:0]          n;
  logic [CW-1:0]          lo;
  logic [CW-1:0]          hi;
  logic [CW-1:0]          idx;
  logic [CW:0]            lohi;
  logic [CW-1:0]          mid;
  logic [24:0]            xs;
  entry_t                 ent;
  entry_t                 rd;
  logic signed [AccW-1:0] acc_t;
  logic signed [AccW-1:0] qacc;
  logic signed [AccW-1:0] sum;
  result_t                fin;
  logic                   accept;
  logic [16:0]            widx;
  logic                   we;
  logic [IW-1:0]          raddr;
  logic                   mul_start;
  logic signed [OpAW-1:0] mul_a;
  logic signed [OpBW-1:0] mul_b;
  shift_t                 mul_sh;
  logic                   mul_done;
  logic signed [AccW-1:0] mul_res;
  logic                   div_done;
  logic signed [AccW-1:0] div_q;
  logic signed [25:0]     dlt;
  logic [25:0]            esum;
  logic signed [AccW-1:0] qsum;
  logic signed [AccW-1:0] qrnd;
  logic                   emit_ok;

  function automatic result_t saturate(input logic signed [AccW-1:0] v);
    result_t o;
    o.status = STATUS_OK;
    o.value  = 48'(v);
    if (v > ValMax) begin
      o.value  = 48'(ValMax);
      o.status = STATUS_SAT;
    end else if (v < ValMin) begin
      o.value  = 48'(ValMin);
      o.status = STATUS_SAT;
    end
    return o;
  endfunction

  assign cfg_ready  = 1'b1;
  assign item_stall = (state != S_IDLE);
  assign accept     = item_valid && !item_stall;
  assign emit_ok    = !result_valid || !result_stall;

  assign n    = (NW'(segment_count) < NW'(MAX_SEGMENTS)) ? CW'(segment_count)
                                                          : CW'(MAX_SEGMENTS);
  assign lohi = {1'b0, lo} + {1'b0, hi};
  assign mid  = lohi[CW:1];

  assign widx = 17'(item.entry_index);
  assign we   = accept && (item.kind == KIND_LOAD) && (widx < 17'(MAX_SEGMENTS));

  assign dlt  = $signed({1'b0, ent.seg_end}) - $signed({1'b0, ent.seg_start});
  assign esum = 26'(ent.seg_end) + 26'(ent.seg_start);
  assign qsum = qacc + mul_res;
  assign qrnd = (qsum + AccW'(1 << 23)) >>> 24;

  always_comb begin
    raddr = lo[IW-1:0];
    if (state == S_SRCH && (hi - lo) > CW'(1)) begin
      raddr = mid[IW-1:0];
    end else if (state == S_IRD) begin
      raddr = idx[IW-1:0];
    end
  end

  // Operand selection for the shared multiplier, one pass per state.
  always_comb begin
    mul_start = 1'b0;
    mul_a     = '0;
    mul_b     = '0;
    mul_sh    = SH_24;
    unique case (state)
      S_SEL: begin
        mul_start = !(rd.seg_start > xs || rd.seg_end < xs);
        mul_a     = OpAW'(rd.coef_quad);
        mul_b     = $signed(OpBW'(xs));
      end
      S_EM1: begin
        mul_start = mul_done;
        mul_a     = OpAW'(mul_res + AccW'(ent.coef_lin));
        mul_b     = $signed(OpBW'(xs));
      end
      S_ILAT: begin
        mul_start = 1'b1;
        mul_a     = OpAW'(rd.coef_const);
        mul_b     = OpBW'($signed({1'b0, rd.seg_end}) - $signed({1'b0, rd.seg_start}));
      end
      S_ITC: begin
        mul_start = mul_done;
        mul_a     = OpAW'(dlt);
        mul_b     = $signed(OpBW'(esum));
      end
      S_IDE: begin
        mul_start = mul_done;
        mul_a     = OpAW'(ent.coef_lin);
        mul_b     = OpBW'(mul_res);
        mul_sh    = SH_25;
      end
      S_ITB: begin
        mul_start = mul_done;
        mul_a     = $signed(OpAW'(ent.seg_end));
        mul_b     = $signed(OpBW'(ent.seg_end));
        mul_sh    = SH_NONE;
      end
      S_IQ1: begin
        mul_start = mul_done;
        mul_a     = $signed(OpAW'(ent.seg_end));
        mul_b     = $signed(OpBW'(ent.seg_start));
        mul_sh    = SH_NONE;
      end
      S_IQ2: begin
        mul_start = mul_done;
        mul_a     = $signed(OpAW'(ent.seg_start));
        mul_b     = $signed(OpBW'(ent.seg_start));
        mul_sh    = SH_NONE;
      end
      S_IQ3: begin
        mul_start = mul_done;
        mul_a     = OpAW'(dlt);
        mul_b     = OpBW'(qrnd);
      end
      S_IQ4: begin
        mul_start = mul_done;
        mul_a     = OpAW'(ent.coef_quad);
        mul_b     = OpBW'(mul_res);
      end
      default: begin
        mul_start = 1'b0;
      end
    endcase
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      state         <= S_IDLE;
      segment_count <= 11'd1024;
      result_valid  <= 1'b0;
    end else begin
      if (cfg_valid && cfg_ready) begin
        segment_count <= cfg_data;
      end
      // A waiting result stays until taken; a new one is loaded from S_EMIT.
      result_valid <= (state == S_EMIT && emit_ok) || (result_valid && result_stall);
      unique case (state)
        S_IDLE: begin
          if (accept) begin
            xs  <= item.sample_x;
            lo  <= '0;
            hi  <= n;
            idx <= '0;
            sum <= '0;
            if (item.kind == KIND_EVALUATE && n == '0) begin
              fin <= '{value: '0, status: STATUS_MISS};
            end else begin
              fin <= '{value: '0, status: STATUS_OK};
            end
            priority if (item.kind == KIND_EVALUATE && n != '0) begin
              state <= S_SRCH;
            end else if (item.kind == KIND_INTEGRATE && n != '0) begin
              state <= S_IRD;
            end else begin
              state <= S_EMIT;
            end
          end
        end
        S_SRCH: begin
          state <= ((hi - lo) > CW'(1)) ? S_SCMP : S_SEL;
        end
        S_SCMP: begin
          if (rd.seg_start <= xs) begin
            lo <= mid;
          end else begin
            hi <= mid;
          end
          state <= S_SRCH;
        end
        S_SEL: begin
          ent <= rd;
          if (rd.seg_start > xs || rd.seg_end < xs) begin
            fin   <= '{value: '0, status: STATUS_MISS};
            state <= S_EMIT;
          end else begin
            state <= S_EM1;
          end
        end
        S_EM1: begin
          if (mul_done) begin
            state <= S_EM2;
          end
        end
        S_EM2: begin
          if (mul_done) begin
            fin   <= saturate(mul_res + AccW'(ent.coef_const));
            state <= S_EMIT;
          end
        end
        S_IRD: begin
          state <= S_ILAT;
        end
        S_ILAT: begin
          ent   <= rd;
          state <= S_ITC;
        end
        S_ITC: begin
          if (mul_done) begin
            acc_t <= mul_res;
            state <= S_IDE;
          end
        end
        S_IDE: begin
          if (mul_done) begin
            state <= S_ITB;
          end
        end
        S_ITB: begin
          if (mul_done) begin
            acc_t <= acc_t + mul_res;
            state <= S_IQ1;
          end
        end
        S_IQ1: begin
          if (mul_done) begin
            qacc  <= mul_res;
            state <= S_IQ2;
          end
        end
        S_IQ2: begin
          if (mul_done) begin
            qacc  <= qsum;
            state <= S_IQ3;
          end
        end
        S_IQ3: begin
          if (mul_done) begin
            state <= S_IQ4;
          end
        end
        S_IQ4: begin
          if (mul_done) begin
            state <= S_ITA;
          end
        end
        S_ITA: begin
          if (mul_done) begin
            sum   <= sum + acc_t;
            state <= S_IDIV;
          end
        end
        S_IDIV: begin
          if (div_done) begin
            if ((idx + CW'(1)) == n) begin
              fin   <= saturate(sum + div_q);
              state <= S_EMIT;
            end else begin
              sum   <= sum + div_q;
              idx   <= idx + CW'(1);
              state <= S_IRD;
            end
          end
        end
        S_EMIT: begin
          if (emit_ok) begin
            result <= fin;
            state  <= S_IDLE;
          end
        end
        default: begin
          state <= S_IDLE;
        end
      endcase
    end
  end

  pqe_table #(
    .DEPTH(MAX_SEGMENTS),
    .IW   (IW)
  ) u_table (
    .clk  (clk),
    .we   (we),
    .waddr(widx[IW-1:0]),
    .wdata('{seg_start: item.seg_start, seg_end: item.seg_end,
             coef_quad: item.coef_quad, coef_lin: item.coef_lin,
             coef_const: item.coef_const}),
    .raddr(raddr),
    .rdata(rd)
  );

  pqe_mul u_mul (
    .clk  (clk),
    .rst  (rst),
    .start(mul_start),
    .op_a (mul_a),
    .op_b (mul_b),
    .sh   (mul_sh),
    .done (mul_done),
    .res  (mul_res)
  );

  pqe_div3 u_div3 (
    .clk  (clk),
    .rst  (rst),
    .start(state == S_ITA && mul_done),
    .v    (mul_res),
    .done (div_done),
    .q    (div_q)
  );

endmodule
